// File: src/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-point alu pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GT   = 4'd4,
        OP_LT   = 4'd5,
        OP_GE   = 4'd6,
        OP_LE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FINT = 4'd14,
        OP_TINT = 4'd15
    } t_op;

    // first stage: operands and the raw product
    typedef struct packed {
        t_op                op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] prod;
    } t_s1;

    // carried through the divider stages
    typedef struct packed {
        t_op         op;
        logic [31:0] res;
        logic        truth;
        logic        dz;
        logic        neg;
        logic [31:0] mag_a;
        logic [31:0] den;
        logic [31:0] rem;
        logic [31:0] quo;
    } t_div;

endpackage
`default_nettype wire

// File: src/fpa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if
// Valid/ready channels for requests and results of the alu.
// ----------------------------------------------------------------------------
interface fpa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, operation, operand_a, operand_b, input ready);
    modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               truth;
    logic               divide_by_zero;

    modport source (output valid, result_value, truth, divide_by_zero, input ready);
    modport sink   (input valid, result_value, truth, divide_by_zero, output ready);
endinterface
`default_nettype wire

// File: src/fpa_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_mul
// Input stage: registers the request and the full 64-bit product.
// ----------------------------------------------------------------------------
module fpa_mul
    import fpa_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  wire                i_valid,
    input  wire  [3:0]         i_operation,
    input  wire  signed [31:0] i_operand_a,
    input  wire  signed [31:0] i_operand_b,
    output logic               o_valid,
    output t_s1                o_data
);

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    always_comb begin
        n_data.op   = t_op'(i_operation);
        n_data.a    = i_operand_a;
        n_data.b    = i_operand_b;
        n_data.prod = 64'(i_operand_a) * 64'(i_operand_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// File: src/fpa_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_prep
// Finishes all non-divide operations and sets up the divider magnitudes.
// ----------------------------------------------------------------------------
module fpa_prep
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_load,
    input  wire   i_valid,
    input  t_s1   i_data,
    output logic  o_valid,
    output t_div  o_data
);

    localparam logic [63:0] BIAS = (64'd1 << FRAC_BITS) - 64'd1;

    logic               r_valid;
    t_div               r_data;
    t_div               n_data;
    logic signed [63:0] prod_adj;
    logic signed [63:0] prod_scl;

    always_comb begin
        // truncate toward zero: bias negative products before the shift
        prod_adj = i_data.prod + (i_data.prod[63] ? $signed(BIAS) : 64'sd0);
        prod_scl = prod_adj >>> FRAC_BITS;

        n_data.op    = i_data.op;
        n_data.res   = '0;
        n_data.truth = 1'b0;
        n_data.dz    = 1'b0;
        n_data.neg   = i_data.a[31] ^ i_data.b[31];
        n_data.mag_a = i_data.a[31] ? 32'(-i_data.a) : i_data.a;
        n_data.den   = i_data.b[31] ? 32'(-i_data.b) : i_data.b;
        n_data.rem   = '0;
        n_data.quo   = '0;
        case (i_data.op)
            OP_ADD:  n_data.res = 32'(i_data.a + i_data.b);
            OP_SUB:  n_data.res = 32'(i_data.a - i_data.b);
            OP_MUL:  n_data.res = prod_scl[31:0];
            OP_DIV:  n_data.dz = (i_data.b == 32'sd0);
            OP_GT:   n_data.truth = (i_data.a > i_data.b);
            OP_LT:   n_data.truth = (i_data.a < i_data.b);
            OP_GE:   n_data.truth = (i_data.a >= i_data.b);
            OP_LE:   n_data.truth = (i_data.a <= i_data.b);
            OP_EQ:   n_data.truth = (i_data.a == i_data.b);
            OP_NE:   n_data.truth = (i_data.a != i_data.b);
            OP_MIN:  n_data.res = (i_data.a < i_data.b) ? i_data.a : i_data.b;
            OP_MAX:  n_data.res = (i_data.a > i_data.b) ? i_data.a : i_data.b;
            OP_INC:  n_data.res = 32'(i_data.a + 32'sd1);
            OP_DEC:  n_data.res = 32'(i_data.a - 32'sd1);
            OP_FINT: n_data.res = i_data.a << FRAC_BITS;
            OP_TINT: n_data.res = i_data.a >>> FRAC_BITS;
            default: n_data.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// File: src/fpa_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring-division stage: brings in one numerator bit, yields one
// quotient bit.
// ----------------------------------------------------------------------------
module fpa_div_step
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT_POS   = 0
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_load,
    input  wire   i_valid,
    input  t_div  i_data,
    output logic  o_valid,
    output t_div  o_data
);

    logic        r_valid;
    t_div        r_data;
    t_div        n_data;
    logic        num_bit;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // numerator is mag_a shifted up by the fraction width
    generate
        if (BIT_POS >= FRAC_BITS) begin : g_abit
            assign num_bit = i_data.mag_a[BIT_POS - FRAC_BITS];
        end else begin : g_zero
            assign num_bit = 1'b0;
        end
    endgenerate

    always_comb begin
        trial      = {i_data.rem, num_bit};
        diff       = trial - {1'b0, i_data.den};
        ge         = (trial >= {1'b0, i_data.den});
        n_data     = i_data;
        n_data.rem = ge ? diff[31:0] : trial[31:0];
        n_data.quo = {i_data.quo[30:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// File: src/fpa_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_post
// Output stage: applies the quotient sign and holds the result.
// ----------------------------------------------------------------------------
module fpa_post
    import fpa_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  wire                i_valid,
    input  t_div               i_data,
    output logic               o_valid,
    output logic signed [31:0] o_result,
    output logic               o_truth,
    output logic               o_dz
);

    logic        r_valid;
    logic [31:0] r_result;
    logic        r_truth;
    logic        r_dz;
    logic [31:0] n_result;

    always_comb begin
        n_result = i_data.res;
        if (i_data.op == OP_DIV) begin
            if (i_data.dz) begin
                n_result = '0;
            end else begin
                n_result = i_data.neg ? 32'(-i_data.quo) : i_data.quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
            r_truth  <= i_data.truth;
            r_dz     <= i_data.dz;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_truth  = r_truth;
    assign o_dz     = r_dz;

endmodule
`default_nettype wire

// File: src/fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed fixed-point alu with a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Usage: requests come in on i_req (operation, operand_a, operand_b) and
// results leave on o_rsp (result_value, truth, divide_by_zero), one result
// per request, in request order, both channels valid/ready.
// Every operation takes the same path: one product stage, one setup stage,
// one restoring divider stage per numerator bit (32 + FRAC_BITS of them)
// and one output stage. The pipeline takes one request per cycle unless
// o_rsp is stalled and every stage is full.
// Each stage holds its own valid bit; a stage loads when it is empty or
// when the stage after it loads, so bubbles close up while o_rsp is
// stalled and requests keep entering until every stage is full. The
// held result stays steady until taken.
// Reset clears all valid bits; the block is ready in the cycle after
// reset is released.
// ----------------------------------------------------------------------------
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fpa_req_if.sink     i_req,
    fpa_rsp_if.source   o_rsp
);

    localparam int NB  = 32 + FRAC_BITS;
    localparam int NST = NB + 3;

    logic [NST-1:0] stg_v;
    logic [NST-1:0] ld;
    t_s1            d_s1;
    t_div           d_step [NB+1];

    // a stage may load when empty or when its successor loads
    always_comb begin
        ld[NST-1] = !stg_v[NST-1] || o_rsp.ready;
        for (int i = NST - 2; i >= 0; i--) begin
            ld[i] = !stg_v[i] || ld[i+1];
        end
    end

    assign i_req.ready = ld[0];

    fpa_mul u_mul (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (ld[0]),
        .i_valid     (i_req.valid),
        .i_operation (i_req.operation),
        .i_operand_a (i_req.operand_a),
        .i_operand_b (i_req.operand_b),
        .o_valid     (stg_v[0]),
        .o_data      (d_s1)
    );

    fpa_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ld[1]),
        .i_valid (stg_v[0]),
        .i_data  (d_s1),
        .o_valid (stg_v[1]),
        .o_data  (d_step[0])
    );

    generate
        for (genvar k = 0; k < NB; k++) begin : g_step
            fpa_div_step #(
                .FRAC_BITS (FRAC_BITS),
                .BIT_POS   (NB - 1 - k)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (ld[k+2]),
                .i_valid (stg_v[k+1]),
                .i_data  (d_step[k]),
                .o_valid (stg_v[k+2]),
                .o_data  (d_step[k+1])
            );
        end
    endgenerate

    fpa_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (ld[NST-1]),
        .i_valid  (stg_v[NST-2]),
        .i_data   (d_step[NB]),
        .o_valid  (stg_v[NST-1]),
        .o_result (o_rsp.result_value),
        .o_truth  (o_rsp.truth),
        .o_dz     (o_rsp.divide_by_zero)
    );

    assign o_rsp.valid = stg_v[NST-1];

`ifndef ASSERT_OFF
    // a zero divisor always gives a zero value and no truth bit
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.divide_by_zero |->
            o_rsp.result_value == 32'sd0 && !o_rsp.truth)
        else $error("divide by zero result not cleared");

    // comparisons leave the value at zero
    a_truth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.truth |-> o_rsp.result_value == 32'sd0)
        else $error("comparison result carries a value");

    // a held output stage never takes new data while the pipeline is stalled
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.result_value))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives fixed-point alu requests with random gaps, predicts each result in
// order and checks all its fields at once against the response channel.
// ----------------------------------------------------------------------------
module tb_top;
    import fpa_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 35;

    typedef struct packed {
        logic signed [31:0] value;
        logic               truth;
        logic               dz;
    } t_alu_result;

    logic i_clk;
    logic i_rst_n;
    fpa_req_if req_if ();
    fpa_rsp_if rsp_if ();

    fixed_point_alu #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    t_alu_result expected_results[$];
    int mismatch_count = 0;
    int orphan_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_alu_result alu_predict(t_op op, logic signed [31:0] a,
                                                logic signed [31:0] b);
        t_alu_result r;
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] wide;
        wa = a;
        wb = b;
        r = '0;
        case (op)
            OP_ADD: r.value = 32'(wa + wb);
            OP_SUB: r.value = 32'(wa - wb);
            OP_MUL: begin
                wide = (wa * wb) / (64'sd1 <<< FRAC);
                r.value = wide[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    wide = (wa <<< FRAC) / wb;
                    r.value = wide[31:0];
                end
            end
            OP_GT: r.truth = a > b;
            OP_LT: r.truth = a < b;
            OP_GE: r.truth = a >= b;
            OP_LE: r.truth = a <= b;
            OP_EQ: r.truth = a == b;
            OP_NE: r.truth = a != b;
            OP_MIN: r.value = (a < b) ? a : b;
            OP_MAX: r.value = (a > b) ? a : b;
            OP_INC: r.value = a + 32'sd1;
            OP_DEC: r.value = a - 32'sd1;
            OP_FINT: r.value = a << FRAC;
            default: r.value = a >>> FRAC;
        endcase
        return r;
    endfunction

    // request driver
    task automatic send_request(t_op op, logic signed [31:0] a, logic signed [31:0] b);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_results.push_back(alu_predict(op, a, b));
    endtask

    // response side: random stalls, in-order compare
    initial begin
        int stall;
        t_alu_result got;
        t_alu_result want;
        stall = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready && i_rst_n) begin
                got = '{rsp_if.result_value, rsp_if.truth, rsp_if.divide_by_zero};
                if (expected_results.size() == 0) begin
                    orphan_count++;
                    if (mismatch_count + orphan_count <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count + orphan_count <= 10)
                            $display("mismatch: exp v=%h t=%b dz=%b got v=%h t=%b dz=%b",
                                     want.value, want.truth, want.dz,
                                     got.value, got.truth, got.dz);
                    end
                end
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
                rsp_if.ready <= (stall == 0);
            end else if (!rsp_if.ready) begin
                if (stall > 0)
                    stall--;
                rsp_if.ready <= (stall == 0);
            end
        end
    end

    function automatic logic signed [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        t_op op;
        send_request(OP_ADD, 32'sh7fff_ffff, 32'sd1);
        send_request(OP_SUB, 32'sh8000_0000, 32'sd1);
        send_request(OP_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_request(OP_MUL, -32'sd3, 32'sd1);
        send_request(OP_DIV, 32'sd5, 32'sd0);
        send_request(OP_DIV, 32'sh8000_0000, -32'sd1);
        send_request(OP_DIV, -32'sd7, 32'sd2);
        send_request(OP_EQ, 32'sd4, 32'sd4);
        send_request(OP_NE, 32'sd4, 32'sd4);
        send_request(OP_INC, 32'sh7fff_ffff, 32'sd9);
        send_request(OP_DEC, 32'sh8000_0000, 32'sd9);
        send_request(OP_FINT, 32'sh00ff_ffff, -32'sd1);
        send_request(OP_TINT, -32'sd1, 32'sd0);
        send_request(OP_TINT, 32'sh7fff_ffff, 32'sd0);
        for (int i = OP_GT; i <= OP_MAX; i++) begin
            op = t_op'(i);
            send_request(op, 32'sh8000_0000, 32'sh7fff_ffff);
        end
    endtask

    task automatic test_drain();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_request(t_op'($urandom_range(0, 15)), random_operand(), random_operand());
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.operation = OP_ADD;
        req_if.operand_a = '0;
        req_if.operand_b = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain();
        test_random(700);
        test_drain();
        test_random(730);
        test_drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatch_count == 0 && orphan_count == 0)
            $display("** fixed_point_alu: PASSED **");
        else
            $display("** fixed_point_alu: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** fixed_point_alu: FAILED **");
        $finish;
    end
endmodule
